FILE: hdl/gyro_pointer_motion_conditioner_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pointer motion conditioner
// Concurrent checks sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GYRO_POINTER_MOTION_CONDITIONER_MACROS_SVH
`define GYRO_POINTER_MOTION_CONDITIONER_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define GPMC_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GPMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/gpmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpmc_pkg
// Widths, register indexes, reset values and the result layout shared by
// the pointer motion conditioner modules.
// ----------------------------------------------------------------------------
package gpmc_pkg;

    localparam int RATE_W    = 20;
    localparam int DEADZ_W   = 11;
    localparam int GAIN_W    = 16;
    localparam int TIMEOUT_W = 16;
    localparam int TOUCH_W   = 16;
    localparam int TIME_W    = 32;
    localparam int STEP_W    = 8;
    localparam int CFG_W     = 16;
    localparam int QUOT_W    = RATE_W + GAIN_W - 24;

    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 24;

    localparam logic [DEADZ_W-1:0]   DEADZONE_RST  = 11'd384;
    localparam logic [GAIN_W-1:0]    GAIN_RST      = 16'd9830;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 16'd3000;
    localparam logic [TOUCH_W-1:0]   THRESHOLD_RST = 16'd40;

    typedef enum logic [1:0] {
        REG_DEADZONE  = 2'd0,
        REG_GAIN      = 2'd1,
        REG_TIMEOUT   = 2'd2,
        REG_THRESHOLD = 2'd3
    } cfg_index_t;

    // Packed from the top bit down; move_valid ends up in bit 0.
    typedef struct packed {
        logic                     idle_flag;
        logic                     right_release;
        logic                     right_press;
        logic                     left_release;
        logic                     left_press;
        logic signed [STEP_W-1:0] move_y;
        logic signed [STEP_W-1:0] move_x;
        logic                     move_valid;
    } result_t;

endpackage

FILE: hdl/gpmc_rate_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpmc_rate_step
// Negates one angular rate, applies the deadzone, scales by the gain and
// saturates the truncated quotient to a signed pointer step.
// ----------------------------------------------------------------------------
module gpmc_rate_step
    import gpmc_pkg::*;
(
    input  logic signed [RATE_W-1:0]  rate,
    input  logic        [DEADZ_W-1:0] deadzone,
    input  logic        [GAIN_W-1:0]  gain,
    output logic signed [STEP_W-1:0]  step
);

    logic                        neg;
    logic [RATE_W-1:0]           mag;
    logic [RATE_W+GAIN_W-1:0]    prod;
    logic [QUOT_W-1:0]           quot;

    // The rate is negated first, so a positive input gives a negative step.
    assign neg  = !rate[RATE_W-1] && (rate != '0);
    assign mag  = rate[RATE_W-1] ? (~rate + RATE_W'(1)) : rate;
    assign prod = (RATE_W+GAIN_W)'(mag) * (RATE_W+GAIN_W)'(gain);
    assign quot = prod[RATE_W+GAIN_W-1:24];

    always_comb
    begin
        if (mag < RATE_W'(deadzone))
        begin
            step = '0;
        end
        else if (neg)
        begin
            if (quot > QUOT_W'(128))
                step = -8'sd128;
            else
                step = STEP_W'(~quot[STEP_W-1:0] + STEP_W'(1));
        end
        else
        begin
            if (quot > QUOT_W'(127))
                step = 8'sd127;
            else
                step = quot[STEP_W-1:0];
        end
    end

endmodule

FILE: hdl/gyro_pointer_motion_conditioner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_pointer_motion_conditioner
// Turns rate sensor samples into pointer steps, click pulses and idle state.
// ----------------------------------------------------------------------------
// Usage:
// A sample enters on the s_ stream when s_tvalid and s_tready are both high.
// Every sample gives exactly one result transaction on the m_ stream.
// The sample is first captured in an input register; the scaling, deadzone,
// saturation, idle timer and touch edge logic then run combinationally into
// the output register.
// Throughput is one sample per cycle while m_tready stays high; the path through the 20 x 16 multiply
// and the saturation that decides motion sets the cycle time.
// If the receiver holds m_tready low, the output register keeps its result
// and the input register holds one more sample; s_tready then drops.
// Registers are written through wr_en, wr_index and wr_data; the user must do so only while
// no sample is in flight, which the block itself does not enforce.
// Reset clears both stages, the idle timer, the pad history and sets the
// registers to their default values.
// ----------------------------------------------------------------------------
`include "gyro_pointer_motion_conditioner_macros.svh"

module gyro_pointer_motion_conditioner
    import gpmc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   wr_en,
    input  logic [1:0]             wr_index,
    input  logic [CFG_W-1:0]       wr_data,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // yaw_rate, pitch_rate, left_touch_level, right_touch_level, now_ms, link_up
    input  logic [IN_TDATA_W-1:0]  s_tdata,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // move_valid, move_x, move_y, left_press, left_release, right_press,
    // right_release, idle_flag
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [DEADZ_W-1:0]   deadzone_reg;
    logic [GAIN_W-1:0]    gain_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [TOUCH_W-1:0]   threshold_reg;

    logic                     in_valid_reg;
    logic signed [RATE_W-1:0] yaw_reg;
    logic signed [RATE_W-1:0] pitch_reg;
    logic [TOUCH_W-1:0]       left_reg;
    logic [TOUCH_W-1:0]       right_reg;
    logic [TIME_W-1:0]        now_reg;
    logic                     link_reg;

    logic [TIME_W-1:0] last_motion_reg;
    logic [TIME_W-1:0] last_motion_next;
    logic              idle_reg;
    logic              idle_next;
    logic              left_before_reg;
    logic              right_before_reg;

    logic    out_valid_reg;
    result_t out_reg;
    result_t result_next;

    logic                     advance;
    logic                     in_take;
    logic signed [STEP_W-1:0] dx;
    logic signed [STEP_W-1:0] dy;
    logic signed [STEP_W-1:0] vy;
    logic                     moving;
    logic                     report;
    logic [TIME_W-1:0]        elapsed;
    logic                     touch_l;
    logic                     touch_r;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg  <= DEADZONE_RST;
            gain_reg      <= GAIN_RST;
            timeout_reg   <= TIMEOUT_RST;
            threshold_reg <= THRESHOLD_RST;
        end
        else if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                REG_DEADZONE:  deadzone_reg  <= wr_data[DEADZ_W-1:0];
                REG_GAIN:      gain_reg      <= wr_data[GAIN_W-1:0];
                REG_TIMEOUT:   timeout_reg   <= wr_data[TIMEOUT_W-1:0];
                REG_THRESHOLD: threshold_reg <= wr_data[TOUCH_W-1:0];
                default:       ;
            endcase
        end
    end

    // Input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            yaw_reg   <= s_tdata[19:0];
            pitch_reg <= s_tdata[39:20];
            left_reg  <= s_tdata[55:40];
            right_reg <= s_tdata[71:56];
            now_reg   <= s_tdata[103:72];
            link_reg  <= s_tdata[104];
        end
    end

    gpmc_rate_step u_step_x
    (
        .rate     (yaw_reg),
        .deadzone (deadzone_reg),
        .gain     (gain_reg),
        .step     (dx)
    );

    gpmc_rate_step u_step_y
    (
        .rate     (pitch_reg),
        .deadzone (deadzone_reg),
        .gain     (gain_reg),
        .step     (dy)
    );

    assign moving  = (dx != '0) || (dy != '0);
    assign elapsed = now_reg - last_motion_reg;
    assign touch_l = left_reg < threshold_reg;
    assign touch_r = right_reg < threshold_reg;
    // Negating the most negative step would overflow, so it clips to +127.
    assign vy      = (dy == -8'sd128) ? 8'sd127 : -dy;

    always_comb
    begin
        last_motion_next = last_motion_reg;
        idle_next        = idle_reg;
        if (moving)
        begin
            last_motion_next = now_reg;
            idle_next        = 1'b0;
        end
        else if (elapsed > TIME_W'(timeout_reg))
        begin
            idle_next = 1'b1;
        end
    end

    assign report = link_reg && !idle_next && moving;

    always_comb
    begin
        result_next.move_valid    = report;
        result_next.move_x        = report ? dx : '0;
        result_next.move_y        = report ? vy : '0;
        result_next.left_press    = link_reg && touch_l && !left_before_reg;
        result_next.left_release  = link_reg && !touch_l && left_before_reg;
        result_next.right_press   = link_reg && touch_r && !right_before_reg;
        result_next.right_release = link_reg && !touch_r && right_before_reg;
        result_next.idle_flag     = idle_next;
    end

    // Sample history and output stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_motion_reg  <= '0;
            idle_reg         <= 1'b0;
            left_before_reg  <= 1'b0;
            right_before_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else if (advance)
        begin
            last_motion_reg  <= last_motion_next;
            idle_reg         <= idle_next;
            left_before_reg  <= touch_l;
            right_before_reg <= touch_r;
            out_valid_reg    <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - $bits(result_t))'(0), out_reg};

    `GPMC_ASSERT_ALWAYS(a_report_not_idle,
        !(out_valid_reg && out_reg.move_valid && out_reg.idle_flag),
        "motion report while idle")
    `GPMC_ASSERT_ALWAYS(a_report_has_motion,
        !(out_valid_reg && out_reg.move_valid &&
          out_reg.move_x == '0 && out_reg.move_y == '0),
        "motion report without motion")
    `GPMC_ASSERT_ALWAYS(a_press_release_excl,
        !(out_valid_reg && ((out_reg.left_press && out_reg.left_release) ||
          (out_reg.right_press && out_reg.right_release))),
        "press and release pulse on the same pad")
    `GPMC_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_reg,
        "processed sample did not reach the output register")

endmodule

FILE: verif/gyro_pointer_motion_conditioner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_pointer_motion_conditioner_tb
// Self-checking bench for the pointer motion conditioner. Sensor samples go
// in on the s_ stream and a scoreboard predicts each result from its own copy
// of the registers, the idle timer and the pad history. Results on the m_
// stream are compared field by field. Both sides idle at random, and several
// register settings are run, the extremes among them.
// ----------------------------------------------------------------------------
module gyro_pointer_motion_conditioner_tb
    import gpmc_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int GAP_PERCENT    = 32;

    typedef struct packed {
        logic                     link_up;
        logic [TIME_W-1:0]        now_ms;
        logic [TOUCH_W-1:0]       right_level;
        logic [TOUCH_W-1:0]       left_level;
        logic signed [RATE_W-1:0] pitch_rate;
        logic signed [RATE_W-1:0] yaw_rate;
    } sample_t;

    class motion_scoreboard;
        logic [DEADZ_W-1:0]   deadzone;
        logic [GAIN_W-1:0]    gain;
        logic [TIMEOUT_W-1:0] timeout_ms;
        logic [TOUCH_W-1:0]   threshold;
        logic [TIME_W-1:0]    last_motion_ms;
        bit                   idle;
        bit                   left_was_touched;
        bit                   right_was_touched;
        result_t              expected_results[$];
        int                   mismatches;

        function new();
            deadzone          = DEADZONE_RST;
            gain              = GAIN_RST;
            timeout_ms        = TIMEOUT_RST;
            threshold         = THRESHOLD_RST;
            last_motion_ms    = '0;
            idle              = 1'b0;
            left_was_touched  = 1'b0;
            right_was_touched = 1'b0;
            mismatches        = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_DEADZONE:  deadzone   = val[DEADZ_W-1:0];
                REG_GAIN:      gain       = val[GAIN_W-1:0];
                REG_TIMEOUT:   timeout_ms = val[TIMEOUT_W-1:0];
                REG_THRESHOLD: threshold  = val[TOUCH_W-1:0];
                default: ;
            endcase
        endfunction

        // Negate, apply the deadzone, scale, truncate toward zero, saturate.
        function logic [STEP_W-1:0] rate_step(logic signed [RATE_W-1:0] rate);
            logic signed [RATE_W+1:0] flipped;
            logic [RATE_W:0]          mag;
            logic [RATE_W+GAIN_W:0]   prod;
            logic [RATE_W+GAIN_W-24:0] quot;
            flipped = -$signed({{2{rate[RATE_W-1]}}, rate});
            mag     = (RATE_W+1)'((flipped < 0) ? -flipped : flipped);
            if (mag < deadzone)
                return '0;
            prod = mag * gain;
            quot = prod[RATE_W+GAIN_W:24];
            if (flipped < 0)
                return (quot > 128) ? 8'h80 : (8'd0 - quot[STEP_W-1:0]);
            return (quot > 127) ? 8'h7F : quot[STEP_W-1:0];
        endfunction

        function void note_sample(sample_t smp);
            logic [STEP_W-1:0] dx;
            logic [STEP_W-1:0] dy;
            logic [STEP_W-1:0] vy;
            logic [TIME_W-1:0] elapsed;
            bit                moving;
            bit                left_touched;
            bit                right_touched;
            bit                report;
            result_t           res;
            dx            = rate_step(smp.yaw_rate);
            dy            = rate_step(smp.pitch_rate);
            moving        = (dx != 0) || (dy != 0);
            left_touched  = smp.left_level < threshold;
            right_touched = smp.right_level < threshold;
            elapsed       = smp.now_ms - last_motion_ms;
            if (moving)
            begin
                last_motion_ms = smp.now_ms;
                idle           = 1'b0;
            end
            else if (elapsed > timeout_ms)
            begin
                idle = 1'b1;
            end
            report = smp.link_up && !idle && moving;
            // Negating the most negative step would overflow, so it clips.
            vy = (dy == 8'h80) ? 8'h7F : (8'd0 - dy);
            res.move_valid    = report;
            res.move_x        = report ? dx : '0;
            res.move_y        = report ? vy : '0;
            res.left_press    = smp.link_up && left_touched && !left_was_touched;
            res.left_release  = smp.link_up && !left_touched && left_was_touched;
            res.right_press   = smp.link_up && right_touched && !right_was_touched;
            res.right_release = smp.link_up && !right_touched && right_was_touched;
            res.idle_flag     = idle;
            left_was_touched  = left_touched;
            right_was_touched = right_touched;
            expected_results.push_back(res);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data);
            result_t got;
            result_t want;
            got = data[$bits(result_t)-1:0];
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %h", data);
                return;
            end
            want = expected_results.pop_front();
            if (got.move_valid !== want.move_valid || got.move_x !== want.move_x ||
                got.move_y !== want.move_y || got.left_press !== want.left_press ||
                got.left_release !== want.left_release ||
                got.right_press !== want.right_press ||
                got.right_release !== want.right_release ||
                got.idle_flag !== want.idle_flag)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: expected v/x/y/lp/lr/rp/rr/idle %b/%0d/%0d/%b/%b/%b/%b/%b",
                             want.move_valid, want.move_x, want.move_y,
                             want.left_press, want.left_release, want.right_press,
                             want.right_release, want.idle_flag);
                    $display("       actual   v/x/y/lp/lr/rp/rr/idle %b/%0d/%0d/%b/%b/%b/%b/%b",
                             got.move_valid, got.move_x, got.move_y,
                             got.left_press, got.left_release, got.right_press,
                             got.right_release, got.idle_flag);
                end
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   wr_en;
    logic [1:0]             wr_index;
    logic [CFG_W-1:0]       wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // yaw_rate, pitch_rate, left_touch_level,
                                       // right_touch_level, now_ms, link_up
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // move_valid, move_x, move_y, left_press,
                                       // left_release, right_press, right_release,
                                       // idle_flag

    motion_scoreboard sb;
    bit               no_gaps;
    int               quiet_cycles;
    logic [TIME_W-1:0] clock_ms;
    bit               left_held;
    bit               right_held;
    int               still_left;

    gyro_pointer_motion_conditioner u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result checking, the receiver's stalls and the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
        m_tready <= no_gaps || ($urandom_range(0, 99) >= GAP_PERCENT);
    end

    function automatic sample_t make_sample(logic signed [RATE_W-1:0] yaw,
                                            logic signed [RATE_W-1:0] pitch,
                                            logic [TOUCH_W-1:0] left_lvl,
                                            logic [TOUCH_W-1:0] right_lvl,
                                            logic [TIME_W-1:0] now, logic link);
        sample_t smp;
        smp.yaw_rate    = yaw;
        smp.pitch_rate  = pitch;
        smp.left_level  = left_lvl;
        smp.right_level = right_lvl;
        smp.now_ms      = now;
        smp.link_up     = link;
        return smp;
    endfunction

    function automatic logic signed [RATE_W-1:0] random_rate(bit still);
        int unsigned       pick;
        logic [RATE_W-1:0] mag;
        pick = still ? 2 : $urandom_range(0, 9);
        if (pick < 2)
            return RATE_W'($urandom);
        case (pick)
            2, 3:    mag = RATE_W'($urandom_range(0, sb.deadzone - 1));
            4:       mag = RATE_W'(sb.deadzone + $urandom_range(0, 2) - 1);
            default: mag = RATE_W'($urandom_range(0, 1 << 17));
        endcase
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    function automatic logic [TOUCH_W-1:0] pad_level(bit held);
        if ($urandom_range(0, 9) == 0)
            return TOUCH_W'($urandom);
        if (held && sb.threshold != 0)
            return TOUCH_W'($urandom_range(0, sb.threshold - 1));
        return TOUCH_W'($urandom_range(sb.threshold, 16'hFFFF));
    endfunction

    // Mostly plausible sensor traffic: steady time, pad presses held for a
    // while, and stretches of stillness long enough to reach idle.
    function automatic sample_t random_sample();
        bit               still;
        int unsigned      pick;
        logic [TIME_W-1:0] step;
        if (still_left == 0 && $urandom_range(0, 99) < 8)
            still_left = $urandom_range(5, 30);
        still = still_left > 0;
        if (still)
            still_left--;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            clock_ms = $urandom;
        else
        begin
            if (pick < 7)
                step = $urandom_range(0, 2 * sb.timeout_ms + 10);
            else if (still)
                step = $urandom_range(0, sb.timeout_ms / 8 + 10);
            else
                step = $urandom_range(0, 40);
            clock_ms = clock_ms + step;
        end
        if ($urandom_range(0, 99) < 15)
            left_held = !left_held;
        if ($urandom_range(0, 99) < 15)
            right_held = !right_held;
        return make_sample(random_rate(still), random_rate(still), pad_level(left_held),
                           pad_level(right_held), clock_ms, $urandom_range(0, 9) != 0);
    endfunction

    task automatic send_sample(sample_t smp);
        while (!no_gaps && $urandom_range(0, 99) < GAP_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(smp);
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_sample(smp);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic apply_settings(logic [CFG_W-1:0] dz, logic [CFG_W-1:0] gn,
                                  logic [CFG_W-1:0] tmo, logic [CFG_W-1:0] thr);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_DEADZONE, dz);
        write_reg(REG_GAIN, gn);
        write_reg(REG_TIMEOUT, tmo);
        write_reg(REG_THRESHOLD, thr);
        wr_en <= 1'b0;
    endtask

    task automatic send_random(int count);
        repeat (count) send_sample(random_sample());
    endtask

    task automatic send_directed();
        // Full-scale rates saturate both ways; the clipped vertical negation too.
        send_sample(make_sample(20'sd0, 20'sd0, 16'd1000, 16'd1000, 32'd0, 1'b1));
        send_sample(make_sample(20'sd524287, -20'sd524288, 16'd1000, 16'd1000, 32'd1, 1'b1));
        send_sample(make_sample(-20'sd524288, 20'sd524287, 16'd1000, 16'd1000, 32'd2, 1'b1));
        // Just inside and on the deadzone edge.
        send_sample(make_sample(20'sd383, -20'sd383, 16'd1000, 16'd1000, 32'd3, 1'b1));
        send_sample(make_sample(20'sd384, -20'sd384, 16'd1000, 16'd1000, 32'd4, 1'b1));
        send_sample(make_sample(20'sd200000, -20'sd3000, 16'd1000, 16'd1000, 32'd5, 1'b1));
        // Motion with the link down gives no report.
        send_sample(make_sample(20'sd20000, 20'sd20000, 16'd1000, 16'd1000, 32'd1000, 1'b0));
        // Pad edges, then the same edges with the link down.
        send_sample(make_sample(20'sd0, 20'sd0, 16'd10, 16'hFFFF, 32'd1001, 1'b1));
        send_sample(make_sample(20'sd0, 20'sd0, 16'hFFFF, 16'd0, 32'd1002, 1'b1));
        send_sample(make_sample(20'sd0, 20'sd0, 16'd0, 16'hFFFF, 32'd1003, 1'b0));
        send_sample(make_sample(20'sd0, 20'sd0, 16'd0, 16'hFFFF, 32'd1004, 1'b1));
        send_sample(make_sample(20'sd0, 20'sd0, 16'd40, 16'd40, 32'd1005, 1'b1));
        send_sample(make_sample(20'sd0, 20'sd0, 16'd39, 16'd39, 32'd1006, 1'b1));
        // Elapsed time equal to the timeout, then one past it.
        send_sample(make_sample(20'sd0, 20'sd0, 16'd39, 16'd39, 32'd4000, 1'b1));
        send_sample(make_sample(20'sd0, 20'sd0, 16'd39, 16'd39, 32'd4001, 1'b1));
        send_sample(make_sample(-20'sd50000, 20'sd50000, 16'd39, 16'd39, 32'd4002, 1'b1));
        // Idle timer across the wrap of the millisecond counter.
        send_sample(make_sample(20'sd60000, 20'sd0, 16'd1000, 16'd1000, 32'hFFFFFF00, 1'b1));
        send_sample(make_sample(20'sd0, 20'sd0, 16'd1000, 16'd1000, 32'h00000100, 1'b1));
        send_sample(make_sample(20'sd0, 20'sd0, 16'd1000, 16'd1000, 32'h00000BB9, 1'b1));
        send_sample(make_sample(20'sd0, 20'sd0, 16'd1000, 16'd1000, 32'hFFFFFFFF, 1'b1));
        send_sample(make_sample(20'sh55555, 20'shAAAAA, 16'h5555, 16'hAAAA, 32'h5555AAAA,
                                1'b1));
    endtask

    initial
    begin
        sb           = new();
        no_gaps      = 1'b0;
        clock_ms     = '0;
        left_held    = 1'b0;
        right_held   = 1'b0;
        still_left   = 0;
        rst_n    <= 1'b0;
        wr_en    <= 1'b0;
        wr_index <= '0;
        wr_data  <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();
        send_random(120);

        apply_settings(16'd1024, 16'hFFFF, 16'd0, 16'hFFFF);
        send_random(100);

        apply_settings(16'd384, 16'd0, 16'hFFFF, 16'd0);
        send_random(80);

        apply_settings(CFG_W'($urandom_range(384, 1024)), CFG_W'($urandom_range(0, 16'hFFFF)),
                       CFG_W'($urandom_range(0, 16'hFFFF)),
                       CFG_W'($urandom_range(0, 16'hFFFF)));
        no_gaps = 1'b1;
        send_random(60);
        no_gaps = 1'b0;
        // Let the pipeline empty completely before sending more.
        drain();
        send_random(60);

        apply_settings(CFG_W'($urandom_range(384, 1024)), CFG_W'($urandom_range(0, 16'hFFFF)),
                       CFG_W'($urandom_range(0, 4000)), CFG_W'($urandom_range(0, 200)));
        send_random(130);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
